FILE: rtl/core/bal_pkg.sv
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types, constants and helpers for the buddy allocator unit.
// ----------------------------------------------------------------------------
package bal_pkg;

  localparam int SIZE_W   = 17;
  localparam int OFFS_W   = 16;
  localparam int ADDR_W   = 16;
  localparam int STAT_W   = 2;
  localparam int ORD_W    = 5;

  localparam int POOL_ORDER_DEF = 16;
  localparam int MIN_ORDER_DEF  = 6;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOM = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BIG = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEARCH,
    ST_APOP,
    ST_ASPLIT,
    ST_FCHK,
    ST_FHEAD,
    ST_FWALK,
    ST_FWDATA,
    ST_FLINK,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic                fin;
    logic [STAT_W-1:0]   status;
    logic [ADDR_W-1:0]   address;
  } res_t;

  // ceil(log2(size)), zero size taken as one byte
  function automatic logic [ORD_W-1:0] ceil_ord(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] s;
    logic [SIZE_W-1:0] v;
    logic [ORD_W-1:0]  p;
    s = (size == '0) ? SIZE_W'(1) : size;
    v = s - SIZE_W'(1);
    p = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) begin
        p = ORD_W'(i + 1);
      end
    end
    return p;
  endfunction

endpackage

FILE: rtl/core/buddy_allocator_lifo_lists_unit.sv
// ----------------------------------------------------------------------------
// buddy_allocator_lifo_lists_unit
// Binary buddy allocator with one LIFO free list per order.
//
//   channel | ports                                    | transfer when
//   --------+------------------------------------------+------------------
//   in      | in_opcode, in_size_bytes, in_block_offset | start && !busy
//   out     | out_address, out_status                  | out_valid (1 cycle)
//
// Steps: one sequencer step per cycle on the single-port link store;
// every request starts with a decode step, then:
//   alloc: search the orders upward for a non-empty list, pop its head and
//   split it down to the asked order; out of memory if the top list is empty;
//   oversize ends at decode. free: merge with the buddy at each order, from a
//   list head or by walking the list to unlink it, then push the final block;
//   a walk stops after one link per minimum block.
// Reset: synchronous; heads hold only the whole pool, no clearing pass.
// The result is registered and shown in the cycle after the last step; the
// receiver cannot stall it.
// ----------------------------------------------------------------------------
module buddy_allocator_lifo_lists_unit #(
  parameter int POOL_ORDER = bal_pkg::POOL_ORDER_DEF,
  parameter int MIN_ORDER  = bal_pkg::MIN_ORDER_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_opcode,
  input  logic [bal_pkg::SIZE_W-1:0]   in_size_bytes,
  input  logic [bal_pkg::OFFS_W-1:0]   in_block_offset,
  output logic                         out_valid,
  output logic [bal_pkg::ADDR_W-1:0]   out_address,
  output logic [bal_pkg::STAT_W-1:0]   out_status
);

  import bal_pkg::*;

  localparam int BW = POOL_ORDER - MIN_ORDER;

  logic            accept;
  logic            ctrl_busy;
  res_t            res;
  logic            mem_en;
  logic            mem_we;
  logic [BW-1:0]   mem_addr;
  logic [BW:0]     mem_wdata;
  logic [BW:0]     mem_rdata;

  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_address_r;
  logic [STAT_W-1:0]   out_status_r;

  assign accept = start && !ctrl_busy;
  assign busy   = ctrl_busy;

  bal_ctrl #(
    .POOL_ORDER (POOL_ORDER),
    .MIN_ORDER  (MIN_ORDER)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .opcode       (in_opcode),
    .size_bytes   (in_size_bytes),
    .block_offset (in_block_offset),
    .busy         (ctrl_busy),
    .res          (res),
    .mem_en       (mem_en),
    .mem_we       (mem_we),
    .mem_addr     (mem_addr),
    .mem_wdata    (mem_wdata),
    .mem_rdata    (mem_rdata)
  );

  bal_link_ram #(
    .ABITS (BW)
  ) u_links (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (res.fin) begin
      out_address_r <= res.address;
      out_status_r  <= res.status;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_address = out_address_r;
  assign out_status  = out_status_r;

endmodule

FILE: rtl/core/bal_link_ram.sv
// ----------------------------------------------------------------------------
// bal_link_ram
// Single-port next-link store, one entry per minimum block, registered read.
// Entry zero reads as the end marker until first written.
// ----------------------------------------------------------------------------
module bal_link_ram #(
  parameter int ABITS = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             we,
  input  logic [ABITS-1:0] addr,
  input  logic [ABITS:0]   wdata,
  output logic [ABITS:0]   rdata
);

  localparam int DEPTH = 1 << ABITS;
  localparam logic [ABITS:0] END_MARK = {1'b1, {ABITS{1'b0}}};

  logic [ABITS:0] mem [DEPTH];
  logic [ABITS:0] q_r;
  logic           link0_ok_r;
  logic           zero_rd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        q_r <= mem[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link0_ok_r <= 1'b0;
      zero_rd_r  <= 1'b0;
    end else begin
      if (en && we && (addr == '0)) begin
        link0_ok_r <= 1'b1;
      end
      if (en && !we) begin
        zero_rd_r <= (addr == '0) && !link0_ok_r;
      end
    end
  end

  assign rdata = zero_rd_r ? END_MARK : q_r;

endmodule

FILE: rtl/core/bal_ctrl.sv
// ----------------------------------------------------------------------------
// bal_ctrl
// Request sequencer: list heads, order decode, split and merge walks over
// the link store.
// ----------------------------------------------------------------------------
module bal_ctrl #(
  parameter int POOL_ORDER = bal_pkg::POOL_ORDER_DEF,
  parameter int MIN_ORDER  = bal_pkg::MIN_ORDER_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic                                opcode,
  input  logic [bal_pkg::SIZE_W-1:0]          size_bytes,
  input  logic [bal_pkg::OFFS_W-1:0]          block_offset,
  output logic                                busy,
  output bal_pkg::res_t                       res,
  output logic                                mem_en,
  output logic                                mem_we,
  output logic [POOL_ORDER-MIN_ORDER-1:0]     mem_addr,
  output logic [POOL_ORDER-MIN_ORDER:0]       mem_wdata,
  input  logic [POOL_ORDER-MIN_ORDER:0]       mem_rdata
);

  import bal_pkg::*;

  localparam int BW      = POOL_ORDER - MIN_ORDER;
  localparam int NORD    = BW + 1;
  localparam int IW      = $clog2(NORD);
  localparam int AF_W    = POOL_ORDER + ADDR_W;
  localparam logic [IW-1:0] TOP_LVL = IW'(NORD - 1);
  localparam logic [BW:0]   END_MARK = {1'b1, {BW{1'b0}}};

  state_t state_r, state_nxt;

  logic [BW:0]        heads_r [NORD];
  logic               op_r;
  logic [SIZE_W-1:0]  size_r;
  logic [OFFS_W-1:0]  offset_r;
  logic [BW-1:0]      blk_r;
  logic [BW:0]        cur_r;
  logic [BW:0]        steps_r;
  logic [IW-1:0]      i_r;
  logic [IW-1:0]      lvl_r;

  logic [ORD_W-1:0]   ord;
  logic [ORD_W-1:0]   k_w;
  logic               too_big;
  logic [IW-1:0]      lvl_dec;
  logic [BW-1:0]      free_blk;
  logic [BW:0]        head_i;
  logic [BW:0]        head_lv;
  logic [IW-1:0]      i_m;
  logic [BW-1:0]      split_blk;
  logic [BW-1:0]      buddy;
  logic [BW-1:0]      merged;
  logic [AF_W-1:0]    addr_full;

  assign ord       = ceil_ord(size_r);
  assign k_w       = (ord < ORD_W'(MIN_ORDER)) ? ORD_W'(MIN_ORDER) : ord;
  assign too_big   = k_w > ORD_W'(POOL_ORDER);
  assign lvl_dec   = IW'(k_w - ORD_W'(MIN_ORDER));
  assign free_blk  = BW'(offset_r >> MIN_ORDER) & ({BW{1'b1}} << lvl_dec);
  assign head_i    = heads_r[i_r];
  assign head_lv   = heads_r[lvl_r];
  assign i_m       = i_r - IW'(1);
  assign split_blk = blk_r ^ (BW'(1) << i_m);
  assign buddy     = blk_r ^ (BW'(1) << lvl_r);
  assign merged    = (buddy < blk_r) ? buddy : blk_r;
  assign addr_full = AF_W'(blk_r) << MIN_ORDER;
  assign busy      = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (too_big)              state_nxt = ST_IDLE;
        else if (op_r == OP_FREE) state_nxt = ST_FCHK;
        else                      state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (!head_i[BW])          state_nxt = ST_APOP;
        else if (i_r == TOP_LVL)  state_nxt = ST_IDLE;
      end
      ST_APOP: begin
        state_nxt = (i_r == lvl_r) ? ST_IDLE : ST_ASPLIT;
      end
      ST_ASPLIT: begin
        if (i_m == lvl_r) state_nxt = ST_IDLE;
      end
      ST_FCHK: begin
        if (lvl_r == TOP_LVL)               state_nxt = ST_PUSH;
        else if (head_lv == {1'b0, buddy})  state_nxt = ST_FHEAD;
        else                                state_nxt = ST_FWALK;
      end
      ST_FHEAD:  state_nxt = ST_FCHK;
      ST_FWALK: begin
        state_nxt = (cur_r[BW] || steps_r[BW]) ? ST_PUSH : ST_FWDATA;
      end
      ST_FWDATA: begin
        state_nxt = (mem_rdata == {1'b0, buddy}) ? ST_FLINK : ST_FWALK;
      end
      ST_FLINK:  state_nxt = ST_FCHK;
      ST_PUSH:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = blk_r;
    mem_wdata   = head_lv;
    res.fin     = 1'b0;
    res.status  = STAT_OK;
    res.address = '0;
    case (state_r)
      ST_DECODE: begin
        if (too_big) begin
          res.fin    = 1'b1;
          res.status = STAT_BIG;
        end
      end
      ST_SEARCH: begin
        if (!head_i[BW]) begin
          mem_en   = 1'b1;
          mem_addr = head_i[BW-1:0];
        end else if (i_r == TOP_LVL) begin
          res.fin    = 1'b1;
          res.status = STAT_OOM;
        end
      end
      ST_APOP: begin
        if (i_r == lvl_r) begin
          res.fin     = 1'b1;
          res.address = addr_full[ADDR_W-1:0];
        end
      end
      ST_ASPLIT: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = split_blk;
        mem_wdata = heads_r[i_m];
        if (i_m == lvl_r) begin
          res.fin     = 1'b1;
          res.address = addr_full[ADDR_W-1:0];
        end
      end
      ST_FCHK: begin
        if ((lvl_r != TOP_LVL) && (head_lv == {1'b0, buddy})) begin
          mem_en   = 1'b1;
          mem_addr = buddy;
        end
      end
      ST_FWALK: begin
        if (!(cur_r[BW] || steps_r[BW])) begin
          mem_en   = 1'b1;
          mem_addr = cur_r[BW-1:0];
        end
      end
      ST_FWDATA: begin
        if (mem_rdata == {1'b0, buddy}) begin
          mem_en   = 1'b1;
          mem_addr = buddy;
        end
      end
      ST_FLINK: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = cur_r[BW-1:0];
        mem_wdata = mem_rdata;
      end
      ST_PUSH: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = blk_r;
        mem_wdata = head_lv;
        res.fin   = 1'b1;
      end
      default: begin
        mem_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int n = 0; n < NORD; n++) begin
        heads_r[n] <= (n == NORD - 1) ? '0 : END_MARK;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_APOP:   heads_r[i_r]   <= mem_rdata;
        ST_ASPLIT: heads_r[i_m]   <= {1'b0, split_blk};
        ST_FHEAD:  heads_r[lvl_r] <= mem_rdata;
        ST_PUSH:   heads_r[lvl_r] <= {1'b0, blk_r};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_r     <= opcode;
          size_r   <= size_bytes;
          offset_r <= block_offset;
        end
      end
      ST_DECODE: begin
        i_r   <= lvl_dec;
        lvl_r <= lvl_dec;
        blk_r <= free_blk;
      end
      ST_SEARCH: begin
        if (!head_i[BW]) begin
          blk_r <= head_i[BW-1:0];
        end else if (i_r != TOP_LVL) begin
          i_r <= i_r + IW'(1);
        end
      end
      ST_ASPLIT: i_r <= i_m;
      ST_FCHK: begin
        cur_r   <= head_lv;
        steps_r <= '0;
      end
      ST_FWDATA: begin
        if (mem_rdata != {1'b0, buddy}) begin
          cur_r   <= mem_rdata;
          steps_r <= steps_r + (BW+1)'(1);
        end
      end
      ST_FHEAD, ST_FLINK: begin
        blk_r <= merged;
        lvl_r <= lvl_r + IW'(1);
      end
      default: ;
    endcase
  end

  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(res.fin))
    else $error("busy dropped without a result");

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_DECODE))
    else $error("accepted request not decoded");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    res.fin |=> !res.fin)
    else $error("two results for one request");

  a_free_no_address: assert property (@(posedge clk) disable iff (!rst_n)
    (res.fin && (op_r == OP_FREE)) |-> (res.address == '0))
    else $error("free returned an address");

endmodule
